// File: hw/rtl/hue_to_rgb_led_pwm_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hue-to-RGB LED PWM core
// Shared wrappers that clock assertions on clock and report through $error.
// ----------------------------------------------------------------------------
`ifndef HUE_TO_RGB_LED_PWM_CORE_DEFINES_SVH
`define HUE_TO_RGB_LED_PWM_CORE_DEFINES_SVH

// Checked only outside reset.
`define HRGB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define HRGB_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// File: hw/rtl/hrgb_pwm_pkg.sv
// ----------------------------------------------------------------------------
// Hue-to-RGB PWM package
// Shared types, reset constants and the gamma table.
// ----------------------------------------------------------------------------
`default_nettype none

package hrgb_pwm_pkg;

   typedef logic [7:0] duty_type;

   // Per-channel control from the top level to one PWM channel.
   typedef struct packed {
      logic     tick;
      logic     buf_load;
      duty_type buf_value;
   } chan_ctl_type;

   localparam duty_type RED_CNT_INIT   = 8'd255;
   localparam duty_type GREEN_CNT_INIT = 8'd170;
   localparam duty_type BLUE_CNT_INIT  = 8'd85;
   localparam duty_type RED_BUF_INIT   = 8'd10;
   localparam duty_type GREEN_BUF_INIT = 8'd80;
   localparam duty_type BLUE_BUF_INIT  = 8'd170;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_HUE  = 1'b1;

   // Gamma table indexed by the top five bits of a channel value.
   function automatic duty_type gamma_lookup(input logic [4:0] idx);
      duty_type g;
      case (idx)
         5'd0:    g = 8'd0;
         5'd1:    g = 8'd1;
         5'd2:    g = 8'd2;
         5'd3:    g = 8'd2;
         5'd4:    g = 8'd2;
         5'd5:    g = 8'd3;
         5'd6:    g = 8'd3;
         5'd7:    g = 8'd4;
         5'd8:    g = 8'd5;
         5'd9:    g = 8'd6;
         5'd10:   g = 8'd7;
         5'd11:   g = 8'd8;
         5'd12:   g = 8'd10;
         5'd13:   g = 8'd11;
         5'd14:   g = 8'd13;
         5'd15:   g = 8'd16;
         5'd16:   g = 8'd19;
         5'd17:   g = 8'd23;
         5'd18:   g = 8'd27;
         5'd19:   g = 8'd32;
         5'd20:   g = 8'd38;
         5'd21:   g = 8'd45;
         5'd22:   g = 8'd54;
         5'd23:   g = 8'd64;
         5'd24:   g = 8'd76;
         5'd25:   g = 8'd91;
         5'd26:   g = 8'd108;
         5'd27:   g = 8'd128;
         5'd28:   g = 8'd152;
         5'd29:   g = 8'd181;
         5'd30:   g = 8'd215;
         5'd31:   g = 8'd255;
         default: g = 8'd0;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hrgb_req_if.sv
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying a timer tick or a hue sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrgb_req_if;
   logic       valid;
   logic       ready;
   logic       event_kind;
   logic [7:0] hue;

   modport source (output valid, output event_kind, output hue, input ready);
   modport sink   (input valid, input event_kind, input hue, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/hrgb_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying the three LED pin levels.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrgb_rsp_if;
   logic valid;
   logic ready;
   logic red_pin;
   logic green_pin;
   logic blue_pin;

   modport source (output valid, output red_pin, output green_pin, output blue_pin,
                   input ready);
   modport sink   (input valid, input red_pin, input green_pin, input blue_pin,
                   output ready);
endinterface

`default_nettype wire

// File: hw/rtl/hue_to_rgb_led_pwm_core.sv
// ----------------------------------------------------------------------------
// Hue-to-RGB LED PWM core
//
// Three-channel 8-bit LED PWM whose duty cycles come from a hue wheel.
// req_bus carries one beat per event: event_kind 0 is a PWM timer tick,
// event_kind 1 is a hue sample. A hue beat reloads the three compare buffers
// through the wheel and gamma table and yields no rsp beat. A tick beat yields
// one rsp beat with the pin levels computed on the previous tick, then steps
// the counters; a buffer takes effect at its channel's counter wrap.
// csr_we/csr_wdata write the invert option (active-low LEDs); write it idle.
// The rsp beat for a tick is valid on the cycle after acceptance.
// Throughput: one beat per cycle, set by the registered counter update and
// the one-deep rsp register. When rsp_bus stalls, the result holds in the rsp
// register and req_bus.ready drops until it is taken.
// Reset (synchronous) restores counters 255/170/85, buffers 10/80/170,
// compares 0, all LEDs off and the first tick's levels as all on.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hue_to_rgb_led_pwm_core_defines.svh"

module hue_to_rgb_led_pwm_core
   import hrgb_pwm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   hrgb_req_if.sink     req_bus,
   hrgb_rsp_if.source   rsp_bus,
   input  wire logic    csr_we,
   input  wire logic    csr_wdata
);

   logic         invert_ff;
   logic         rsp_valid_ff;
   logic [2:0]   rsp_pins_ff;
   logic         req_acc;
   logic         tick_acc;
   logic         hue_acc;
   duty_type     red_duty, green_duty, blue_duty;
   chan_ctl_type red_ctl, green_ctl, blue_ctl;
   logic [2:0]   level;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_acc  = req_bus.valid && req_bus.ready;
   assign tick_acc = req_acc && (req_bus.event_kind == KIND_TICK);
   assign hue_acc  = req_acc && (req_bus.event_kind == KIND_HUE);

   hrgb_wheel u_wheel (
      .hue        (req_bus.hue),
      .red_duty   (red_duty),
      .green_duty (green_duty),
      .blue_duty  (blue_duty)
   );

   assign red_ctl   = '{tick: tick_acc, buf_load: hue_acc, buf_value: red_duty};
   assign green_ctl = '{tick: tick_acc, buf_load: hue_acc, buf_value: green_duty};
   assign blue_ctl  = '{tick: tick_acc, buf_load: hue_acc, buf_value: blue_duty};

   hrgb_pwm_chan #(.CNT_INIT(RED_CNT_INIT), .BUF_INIT(RED_BUF_INIT)) u_red (
      .clock (clock), .reset (reset), .ctl (red_ctl), .level (level[0])
   );
   hrgb_pwm_chan #(.CNT_INIT(GREEN_CNT_INIT), .BUF_INIT(GREEN_BUF_INIT)) u_green (
      .clock (clock), .reset (reset), .ctl (green_ctl), .level (level[1])
   );
   hrgb_pwm_chan #(.CNT_INIT(BLUE_CNT_INIT), .BUF_INIT(BLUE_BUF_INIT)) u_blue (
      .clock (clock), .reset (reset), .ctl (blue_ctl), .level (level[2])
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            invert_ff <= csr_wdata;
         end
         if (tick_acc) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Emit the levels from the previous tick, inverted for active-low LEDs.
   always_ff @(posedge clock) begin
      if (tick_acc) begin
         rsp_pins_ff <= level ^ {3{invert_ff}};
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.red_pin   = rsp_pins_ff[0];
   assign rsp_bus.green_pin = rsp_pins_ff[1];
   assign rsp_bus.blue_pin  = rsp_pins_ff[2];

   `HRGB_ASSERT(a_tick_gives_beat, tick_acc |=> rsp_valid_ff, "tick did not produce a response beat")
   `HRGB_ASSERT(a_beat_from_tick, $rose(rsp_valid_ff) |-> $past(tick_acc), "response beat without a tick")
   `HRGB_ASSERT(a_hue_no_beat, (hue_acc && !rsp_bus.ready) |=> (rsp_valid_ff == $past(rsp_valid_ff)), "hue sample changed response valid")

endmodule

`default_nettype wire

// File: hw/rtl/hrgb_wheel.sv
// ----------------------------------------------------------------------------
// Hue wheel and gamma
// Maps an 8-bit hue to gamma-corrected red, green and blue duty values.
// ----------------------------------------------------------------------------
`default_nettype none

module hrgb_wheel
   import hrgb_pwm_pkg::*;
(
   input  wire logic [7:0] hue,
   output duty_type        red_duty,
   output duty_type        green_duty,
   output duty_type        blue_duty
);

   localparam logic [7:0] SECT1_END = 8'd42;
   localparam logic [7:0] SECT2_END = 8'd85;
   localparam logic [7:0] SECT3_END = 8'd127;
   localparam logic [7:0] SECT4_END = 8'd170;
   localparam logic [7:0] SECT5_END = 8'd212;
   localparam logic [7:0] FULL      = 8'd255;

   // Slope of six per hue step, wrapped to 8 bits.
   function automatic logic [7:0] times6(input logic [7:0] x);
      return 8'({x, 2'b00} + {1'b0, x, 1'b0});
   endfunction

   logic [7:0] red_lin;
   logic [7:0] green_lin;
   logic [7:0] blue_lin;

   always_comb begin
      if (hue <= SECT1_END) begin
         red_lin = FULL;                      green_lin = times6(hue);
         blue_lin = 8'd0;
      end else if (hue <= SECT2_END) begin
         red_lin = times6(SECT2_END - hue);   green_lin = FULL;
         blue_lin = 8'd0;
      end else if (hue <= SECT3_END) begin
         red_lin = 8'd0;                      green_lin = FULL;
         blue_lin = times6(hue - SECT2_END);
      end else if (hue <= SECT4_END) begin
         red_lin = 8'd0;                      green_lin = times6(SECT4_END - hue);
         blue_lin = FULL;
      end else if (hue <= SECT5_END) begin
         red_lin = times6(hue - SECT4_END);   green_lin = 8'd0;
         blue_lin = FULL;
      end else begin
         red_lin = FULL;                      green_lin = 8'd0;
         blue_lin = times6(FULL - hue);
      end
   end

   assign red_duty   = gamma_lookup(red_lin[7:3]);
   assign green_duty = gamma_lookup(green_lin[7:3]);
   assign blue_duty  = gamma_lookup(blue_lin[7:3]);

endmodule

`default_nettype wire

// File: hw/rtl/hrgb_pwm_chan.sv
// ----------------------------------------------------------------------------
// PWM channel
// Free-running counter, double-buffered compare and LED on/off flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hue_to_rgb_led_pwm_core_defines.svh"

module hrgb_pwm_chan
   import hrgb_pwm_pkg::*;
#(
   parameter duty_type CNT_INIT = RED_CNT_INIT,
   parameter duty_type BUF_INIT = RED_BUF_INIT
)
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  chan_ctl_type ctl,
   output logic        level
);

   duty_type cnt_ff, cnt_in;
   duty_type cmp_ff, cmp_in;
   duty_type buf_ff;
   logic     on_ff, on_in;
   logic     pend_ff;
   logic     wrap;

   always_comb begin
      cnt_in = 8'(cnt_ff + 8'd1);
      wrap   = (cnt_in == 8'd0);
      cmp_in = wrap ? buf_ff : cmp_ff;
      // Off wins over the wrap turn-on when both hit on the same tick.
      on_in  = (on_ff | wrap) & (cmp_in != cnt_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= CNT_INIT;
         cmp_ff  <= 8'd0;
         buf_ff  <= BUF_INIT;
         on_ff   <= 1'b0;
         pend_ff <= 1'b1;
      end else begin
         if (ctl.buf_load) begin
            buf_ff <= ctl.buf_value;
         end
         if (ctl.tick) begin
            cnt_ff  <= cnt_in;
            cmp_ff  <= cmp_in;
            on_ff   <= on_in;
            pend_ff <= on_in;
         end
      end
   end

   assign level = pend_ff;

   `HRGB_ASSERT(a_wrap_loads_cmp, (ctl.tick && cnt_ff == 8'hFF) |=> (cmp_ff == $past(buf_ff)), "compare not loaded from buffer on wrap")
   `HRGB_ASSERT(a_zero_cmp_off, (ctl.tick && cnt_ff == 8'hFF && buf_ff == 8'd0) |=> !pend_ff, "zero compare left LED on")
   `HRGB_ASSERT(a_idle_flag_holds, (ctl.tick && cnt_in != 8'd0 && cnt_in != cmp_ff) |=> (on_ff == $past(on_ff)), "LED flag changed without wrap or match")

endmodule

`default_nettype wire

// File: test/tb_hue_to_rgb_led_pwm_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the hue-to-RGB LED PWM core
// Drives tick and hue beats with random gaps and back-pressure, and predicts
// the counters, compares, gamma-mapped buffers and pin levels. Each rsp beat
// is checked against the oldest predicted pin triple, under both polarities.
// ----------------------------------------------------------------------------

module tb_hue_to_rgb_led_pwm_core;
   import hrgb_pwm_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned PHASE_ITEMS    = 250;

   // Predicts the pin levels of every tick and checks rsp beats against them.
   class led_pin_scoreboard;
      logic [7:0]  pwm_cnt [3];
      logic [7:0]  active_cmp [3];
      logic [7:0]  cmp_buf [3];
      logic [2:0]  led_lit;
      logic [2:0]  next_levels;
      logic        invert;
      logic [7:0]  gamma_tab [32];
      logic [2:0]  pin_levels_q [$];
      int unsigned errors;

      function new();
         gamma_tab = '{8'd0, 8'd1, 8'd2, 8'd2, 8'd2, 8'd3, 8'd3, 8'd4,
                       8'd5, 8'd6, 8'd7, 8'd8, 8'd10, 8'd11, 8'd13, 8'd16,
                       8'd19, 8'd23, 8'd27, 8'd32, 8'd38, 8'd45, 8'd54, 8'd64,
                       8'd76, 8'd91, 8'd108, 8'd128, 8'd152, 8'd181, 8'd215,
                       8'd255};
         pwm_cnt     = '{8'd255, 8'd170, 8'd85};
         active_cmp  = '{8'd0, 8'd0, 8'd0};
         cmp_buf     = '{8'd10, 8'd80, 8'd170};
         led_lit     = 3'b000;
         next_levels = 3'b111;
         invert      = 1'b0;
         errors      = 0;
      endfunction

      function void set_invert(logic v);
         invert = v;
      endfunction

      function int pending();
         return pin_levels_q.size();
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 10)
            $display("%0t mismatch: %s", $realtime, msg);
      endfunction

      // Map a hue through the six-sector wheel and gamma table into the buffers.
      function void load_hue(logic [7:0] h);
         int r;
         int g;
         int b;
         if (h <= 42) begin
            r = 255; g = h * 6; b = 0;
         end else if (h <= 85) begin
            r = (85 - h) * 6; g = 255; b = 0;
         end else if (h <= 127) begin
            r = 0; g = 255; b = (h - 85) * 6;
         end else if (h <= 170) begin
            r = 0; g = (170 - h) * 6; b = 255;
         end else if (h <= 212) begin
            r = (h - 170) * 6; g = 0; b = 255;
         end else begin
            r = 255; g = 0; b = (255 - h) * 6;
         end
         cmp_buf[0] = gamma_tab[r[7:3]];
         cmp_buf[1] = gamma_tab[g[7:3]];
         cmp_buf[2] = gamma_tab[b[7:3]];
      endfunction

      // Emit last tick's levels, then step the counters; a match beats a wrap.
      function void step_pwm();
         pin_levels_q.push_back(next_levels ^ {3{invert}});
         for (int ch = 0; ch < 3; ch++) begin
            pwm_cnt[ch] = pwm_cnt[ch] + 8'd1;
            if (pwm_cnt[ch] == 8'd0) begin
               active_cmp[ch] = cmp_buf[ch];
               led_lit[ch]    = 1'b1;
            end
            if (active_cmp[ch] == pwm_cnt[ch])
               led_lit[ch] = 1'b0;
         end
         next_levels = led_lit;
      endfunction

      function void note_req(logic kind, logic [7:0] h);
         if (kind == KIND_HUE)
            load_hue(h);
         else
            step_pwm();
      endfunction

      function void check_rsp(logic r, logic g, logic b);
         logic [2:0] want;
         if (pin_levels_q.size() == 0) begin
            report($sformatf("rsp beat with nothing expected: r=%b g=%b b=%b", r, g, b));
            return;
         end
         want = pin_levels_q.pop_front();
         if (r !== want[0])
            report($sformatf("red_pin expected %b actual %b", want[0], r));
         if (g !== want[1])
            report($sformatf("green_pin expected %b actual %b", want[1], g));
         if (b !== want[2])
            report($sformatf("blue_pin expected %b actual %b", want[2], b));
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   hrgb_req_if req ();
   hrgb_rsp_if rsp ();

   hue_to_rgb_led_pwm_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req),
      .rsp_bus   (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   led_pin_scoreboard sb;
   bit                send_calm;
   int unsigned       quiet_cycles;
   logic [7:0]        wheel_corners [12] = '{8'd0, 8'd42, 8'd43, 8'd85, 8'd86, 8'd127,
                                             8'd128, 8'd170, 8'd171, 8'd212, 8'd213,
                                             8'd255};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one beat after a random number of idle cycles; return once it is taken.
   task automatic send_item(input logic kind, input logic [7:0] h);
      while (!send_calm && $urandom_range(99) < 35) begin
         req.valid      <= 1'b0;
         req.event_kind <= 1'($urandom_range(1));
         req.hue        <= 8'($urandom_range(255));
         @(posedge clock);
      end
      req.valid      <= 1'b1;
      req.event_kind <= kind;
      req.hue        <= h;
      do
         @(posedge clock);
      while (!req.ready);
   endtask

   // Drop valid and hold until every predicted beat has arrived.
   task automatic drain_results();
      req.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_invert(input logic v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_invert(v);
      csr_we    <= 1'b0;
   endtask

   task automatic send_random_item();
      logic [7:0] h;
      if ($urandom_range(3) == 0)
         h = wheel_corners[$urandom_range(11)];
      else
         h = 8'($urandom_range(255));
      if ($urandom_range(9) == 0)
         send_item(KIND_HUE, h);
      else
         send_item(KIND_TICK, h);
   endtask

   // Receiver: random ready, one long hold-off, and a stretch with no stalls.
   initial begin
      int unsigned taken;
      bit          held;
      taken = 0;
      held  = 1'b0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp.valid && rsp.ready)
            taken++;
         if (!held && taken >= 250) begin
            held = 1'b1;
            rsp.ready <= 1'b0;
            repeat (60) @(posedge clock);
         end else if (taken >= 500 && taken < 650) begin
            rsp.ready <= 1'b1;
         end else begin
            rsp.ready <= ($urandom_range(99) >= 35);
         end
      end
   end

   // Monitor both channels and watch for a stuck handshake.
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready)
            sb.note_req(req.event_kind, req.hue);
         if (rsp.valid && rsp.ready)
            sb.check_rsp(rsp.red_pin, rsp.green_pin, rsp.blue_pin);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[hue_to_rgb_led_pwm_core] ERROR");
            $finish;
         end
      end
   end

   initial begin
      sb           = new();
      send_calm    = 1'b0;
      quiet_cycles = 0;
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_wdata      <= 1'b0;
      req.valid      <= 1'b0;
      req.event_kind <= KIND_TICK;
      req.hue        <= 8'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_invert(1'b0);

      // Directed: ignored hue on ticks, then every wheel sector boundary.
      send_item(KIND_TICK, 8'd255);
      send_item(KIND_TICK, 8'd0);
      foreach (wheel_corners[i]) begin
         send_item(KIND_HUE, wheel_corners[i]);
         send_item(KIND_TICK, ~wheel_corners[i]);
      end

      for (int phase = 0; phase < 4; phase++) begin
         drain_results();
         write_invert(~phase[0]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_calm = (phase == 2 && n < 150);
            // Pause the sender once mid-run until the pipe is empty.
            if (phase == 1 && n == PHASE_ITEMS / 2)
               drain_results();
            send_random_item();
         end
      end
      send_calm = 1'b0;

      drain_results();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("[hue_to_rgb_led_pwm_core] OK");
      else
         $display("[hue_to_rgb_led_pwm_core] ERROR");
      $finish;
   end

endmodule
